// ===== rtl/prs80_pkg.sv =====
`default_nettype none

package prs80_pkg;

  // Widths fixed by the block and key formats
  localparam int BLOCK_W         = 64;
  localparam int KEY_W           = 80;
  localparam int KEY_HIGH_W      = 16;
  localparam int KEY_LOW_W       = 64;
  localparam int KEY_TABLE_DEPTH = 32;
  localparam int RK_IDX_W        = 5;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

  // Operation of the shared round unit
  typedef enum logic [1:0] {
    OP_ENC = 2'b00,
    OP_DEC = 2'b01,
    OP_XOR = 2'b10
  } round_op_t;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      4'hF: y = 4'h2;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'h5;
      4'h1: y = 4'hE;
      4'h2: y = 4'hF;
      4'h3: y = 4'h8;
      4'h4: y = 4'hC;
      4'h5: y = 4'h1;
      4'h6: y = 4'h2;
      4'h7: y = 4'hD;
      4'h8: y = 4'hB;
      4'h9: y = 4'h4;
      4'hA: y = 4'h6;
      4'hB: y = 4'h3;
      4'hC: y = 4'h0;
      4'hD: y = 4'h7;
      4'hE: y = 4'h9;
      4'hF: y = 4'hA;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_fwd(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] o;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      o[4*n +: 4] = sbox_fwd(s[4*n +: 4]);
    end
    return o;
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_inv(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] o;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      o[4*n +: 4] = sbox_inv(s[4*n +: 4]);
    end
    return o;
  endfunction

  // Bit i moves to 16*i mod 63; the top bit stays in place
  function automatic logic [BLOCK_W-1:0] perm_fwd(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] o;
    for (int i = 0; i < BLOCK_W; i++) begin
      o[(i == BLOCK_W - 1) ? i : (16 * i) % (BLOCK_W - 1)] = s[i];
    end
    return o;
  endfunction

  function automatic logic [BLOCK_W-1:0] perm_inv(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] o;
    for (int i = 0; i < BLOCK_W; i++) begin
      o[i] = s[(i == BLOCK_W - 1) ? i : (16 * i) % (BLOCK_W - 1)];
    end
    return o;
  endfunction

  // One key schedule update: rotate left by 61, S-box on the top nibble,
  // round counter into bits 19..15
  function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
                                                  input logic [RK_IDX_W-1:0] ctr);
    logic [KEY_W-1:0] n;
    n = {k[18:0], k[KEY_W-1:19]};
    n[KEY_W-1 -: 4] = sbox_fwd(n[KEY_W-1 -: 4]);
    n[19:15] = n[19:15] ^ ctr;
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/prs80_key_sched.sv =====
`default_nettype none

module prs80_key_sched (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [prs80_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [prs80_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [prs80_pkg::RK_IDX_W-1:0]   rk_idx,
  output logic      [prs80_pkg::BLOCK_W-1:0]    rk,
  output logic                                  busy
);
  import prs80_pkg::*;

  logic [KEY_HIGH_W-1:0] key_high_r, key_high_nxt;
  logic [KEY_LOW_W-1:0]  key_low_r, key_low_nxt;
  logic [KEY_W-1:0]      kreg_r, kreg_nxt;
  logic [RK_IDX_W-1:0]   cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic [BLOCK_W-1:0]    table_r [KEY_TABLE_DEPTH];
  logic [BLOCK_W-1:0]    rk_r;

  // Step the expansion sweep; take key writes and restart the sweep from the new key
  always_comb begin
    key_high_nxt = key_high_r;
    key_low_nxt  = key_low_r;
    kreg_nxt     = kreg_r;
    cnt_nxt      = cnt_r;
    busy_nxt     = busy_r;
    if (busy_r) begin
      kreg_nxt = key_update(kreg_r, cnt_r + RK_IDX_W'(1));
      cnt_nxt  = cnt_r + RK_IDX_W'(1);
      if (cnt_r == RK_IDX_W'(KEY_TABLE_DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end
    end
    if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_HIGH: begin
          key_high_nxt = cfg_wdata[KEY_HIGH_W-1:0];
          kreg_nxt     = {cfg_wdata[KEY_HIGH_W-1:0], key_low_r};
        end
        REG_KEY_LOW: begin
          key_low_nxt = cfg_wdata;
          kreg_nxt    = {key_high_r, cfg_wdata};
        end
        default: begin
          kreg_nxt = {key_high_r, key_low_r};
        end
      endcase
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      kreg_r     <= '0;
      cnt_r      <= '0;
      busy_r     <= 1'b1;
    end else begin
      key_high_r <= key_high_nxt;
      key_low_r  <= key_low_nxt;
      kreg_r     <= kreg_nxt;
      cnt_r      <= cnt_nxt;
      busy_r     <= busy_nxt;
    end
  end

  // Store one round key per cycle of the sweep; register the addressed key
  // so that it is ready in the cycle after the address is given
  always_ff @(posedge clk) begin
    if (busy_r) begin
      table_r[cnt_r] <= kreg_r[KEY_W-1 -: BLOCK_W];
    end
    rk_r <= table_r[rk_idx];
  end

  assign rk   = rk_r;
  assign busy = busy_r;

endmodule

`default_nettype wire

// ===== rtl/prs80_round.sv =====
`default_nettype none

module prs80_round (
  input  wire logic [prs80_pkg::BLOCK_W-1:0] state_in,
  input  wire logic [prs80_pkg::BLOCK_W-1:0] rk,
  input  wire prs80_pkg::round_op_t          op,
  output logic      [prs80_pkg::BLOCK_W-1:0] state_out
);
  import prs80_pkg::*;

  // One encryption round, one decryption round or the bare key XOR
  always_comb begin
    unique case (op)
      OP_ENC:  state_out = perm_fwd(sub_fwd(state_in ^ rk));
      OP_DEC:  state_out = sub_inv(perm_inv(state_in)) ^ rk;
      OP_XOR:  state_out = state_in ^ rk;
      default: state_out = state_in ^ rk;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/present80_block_cipher.sv =====
`default_nettype none

// Channel  | Handshake              | Payload
// ---------+------------------------+-------------------------------------
// input    | in_valid / in_ready    | in_command, in_data_in
// result   | out_valid / out_ready  | out_data_out
// config   | cfg_we                 | cfg_index, cfg_wdata
//
// A block runs through the shared round unit one round or key XOR per cycle;
// a new block is accepted only once the result of the last one has gone
// to the output register.
// After reset and after each key write in_ready stays low for the
// round key sweep. A waiting result does not block the next block; a second
// result holds in the datapath until the output register frees.
module present80_block_cipher #(
  parameter int ROUND_COUNT = 31
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_command,
  input  wire logic [prs80_pkg::BLOCK_W-1:0]    in_data_in,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [prs80_pkg::BLOCK_W-1:0]    out_data_out,
  input  wire logic                             cfg_we,
  input  wire logic [prs80_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [prs80_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import prs80_pkg::*;

  localparam logic [RK_IDX_W-1:0] RC_IDX = RK_IDX_W'(ROUND_COUNT);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [BLOCK_W-1:0]   s_r, s_nxt;
  logic                 cmd_r, cmd_nxt;
  logic [RK_IDX_W-1:0]  cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BLOCK_W-1:0]   out_data_r, out_data_nxt;
  logic [BLOCK_W-1:0]   rk;
  logic [BLOCK_W-1:0]   round_out;
  logic                 ks_busy;
  logic                 done;
  logic                 out_free;
  round_op_t            op;

  // The key table registers its read, so address it with the next count
  prs80_key_sched u_ks (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rk_idx    (cnt_nxt),
    .rk        (rk),
    .busy      (ks_busy)
  );

  prs80_round u_round (
    .state_in  (s_r),
    .rk        (rk),
    .op        (op),
    .state_out (round_out)
  );

  // Pick the step: the key XOR sits at index ROUND_COUNT in both directions
  always_comb begin
    priority if (cnt_r == RC_IDX) begin
      op = OP_XOR;
    end else if (cmd_r) begin
      op = OP_DEC;
    end else begin
      op = OP_ENC;
    end
  end

  assign done     = cmd_r ? (cnt_r == '0) : (cnt_r == RC_IDX);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && !ks_busy;

  // Sequence the rounds and hand the result to the output register
  always_comb begin
    state_nxt     = state_r;
    s_nxt         = s_r;
    cmd_nxt       = cmd_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          s_nxt     = in_data_in;
          cmd_nxt   = in_command;
          cnt_nxt   = in_command ? RC_IDX : '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        s_nxt   = round_out;
        cnt_nxt = cmd_r ? cnt_r - RK_IDX_W'(1) : cnt_r + RK_IDX_W'(1);
        if (done) begin
          if (out_free) begin
            out_data_nxt  = round_out;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_data_nxt  = s_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmd_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the block state and the result; no reset needed
  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/prs80_checker.sv =====
`default_nettype none

module prs80_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [prs80_pkg::BLOCK_W-1:0] out_data_out,
  input wire logic                          cfg_we
);

  // A waiting result holds its value until the transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_out))
    else $error("result dropped or changed before transfer");

  // One block at a time: busy straight after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a block is in flight");

  // A key write starts the table sweep, which blocks input
  a_busy_after_key: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input ready while round keys are being rebuilt");

  // No result can appear in the cycle after an input transfer
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // Reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind present80_block_cipher prs80_checker u_prs80_checker (.*);

`default_nettype wire
